/* rtl/core/sacf_pkg.sv */
package sacf_pkg;

	typedef struct packed {
		logic signed [23:0] target_angle;
		logic               stop;
	} sacf_in_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       last;
	} sacf_out_t;

	// Byte slots of the eleven-byte command frame, in the order they go out.
	typedef enum logic [3:0] {
		POS_SOF    = 4'd0,
		POS_ZERO   = 4'd1,
		POS_ID     = 4'd2,
		POS_CMD    = 4'd3,
		POS_LEN    = 4'd4,
		POS_D0     = 4'd5,
		POS_D1     = 4'd6,
		POS_D2     = 4'd7,
		POS_D3     = 4'd8,
		POS_CRC_LO = 4'd9,
		POS_CRC_HI = 4'd10
	} frame_pos_t;

	localparam logic [7:0] BYTE_SOF  = 8'h3E;
	localparam logic [7:0] BYTE_ZERO = 8'h00;
	localparam logic [7:0] BYTE_CMD  = 8'h55;
	localparam logic [7:0] BYTE_LEN  = 8'h04;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// Half and full turn in 1/256 degree units.
	localparam logic signed [24:0] HALF_TURN = 25'sd46080;
	localparam logic [31:0]        FULL_TURN = 32'd92160;

	// counts = floor(mag * 8 / 45); RECIP = floor(2^35 / 45) leaves at most one short.
	localparam logic [29:0] RECIP   = 30'd763549741;
	localparam logic [5:0]  DIVISOR = 6'd45;

endpackage

/* rtl/core/servo_angle_command_framer.sv */
// Servo angle command framer. Each input transaction (a target angle in signed 1/256 degree
// units and a stop flag) produces one eleven-byte relative-position command frame on the
// output channel, one byte per output transaction, with last set on the CRC high byte.
// A jump of more than half a turn from the previous target moves the kept zero offset by a
// full turn the other way; the command angle (target plus offset, or the offset alone on
// stop) is converted to encoder counts as trunc(angle * 8 / 45) and sent little-endian,
// followed by the CRC-16/MODBUS of the first nine bytes. An input passes stages s1, s2, s3
// and s4 before the serializer loads it; the serializer takes the next frame from s4 as the
// last byte of the current one is accepted. Up to four further inputs are held in the
// conversion pipeline while a frame goes out. Write motor_index via cfg_wr_en and
// cfg_wr_data only while no frame is pending; the block does not enforce it. The frame id byte is motor_index + 1.
module servo_angle_command_framer
	import sacf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  sacf_in_t   in_item,
	output logic       out_valid,
	input  logic       out_stall,
	output sacf_out_t  out_item
);

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	logic [7:0]         motor_index_q;
	logic [31:0]        offset_q;
	logic signed [23:0] prev_q;

	logic               valid_s1, valid_s2, valid_s3, valid_s4;
	logic signed [23:0] target_s1;
	logic               stop_s1;
	logic [31:0]        offset_s1;
	logic [31:0]        mag_s2, mag_s3;
	logic               neg_s2, neg_s3, neg_s4;
	logic [61:0]        prod_s3;
	logic [29:0]        quot_s4;

	logic               ser_valid_q;
	frame_pos_t         pos_q;
	logic [31:0]        counts_q;
	logic [15:0]        crc_q;

	logic               rdy1, rdy2, rdy3, rdy4, ser_load;
	logic               in_acc, out_acc;
	logic signed [24:0] diff;
	logic [31:0]        offset_next;
	logic [31:0]        angle;
	logic [29:0]        quot_est;
	logic [34:0]        rem;
	logic [29:0]        quot;
	logic [7:0]         byte_c;

	// Flow control: each stage moves when it is empty or its successor moves.
	assign out_acc  = out_valid && !out_stall;
	assign ser_load = !ser_valid_q || (out_acc && pos_q == POS_CRC_HI);
	assign rdy4     = !valid_s4 || ser_load;
	assign rdy3     = !valid_s3 || rdy4;
	assign rdy2     = !valid_s2 || rdy3;
	assign rdy1     = !valid_s1 || rdy2;
	assign in_stall = !rdy1;
	assign in_acc   = in_valid && rdy1;

	// Offset tracking on the incoming target.
	always_comb begin
		diff = {in_item.target_angle[23], in_item.target_angle} - {prev_q[23], prev_q};
		if (diff > HALF_TURN) begin
			offset_next = offset_q - FULL_TURN;
		end else if (diff < -HALF_TURN) begin
			offset_next = offset_q + FULL_TURN;
		end else begin
			offset_next = offset_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motor_index_q <= '0;
			offset_q      <= '0;
			prev_q        <= '0;
		end else begin
			if (cfg_wr_en) begin
				motor_index_q <= cfg_wr_data;
			end
			if (in_acc) begin
				offset_q <= offset_next;
				prev_q   <= in_item.target_angle;
			end
		end
	end

	always_comb begin
		if (stop_s1) begin
			angle = offset_s1;
		end else begin
			angle = offset_s1 + {{8{target_s1[23]}}, target_s1};
		end
	end

	// The estimate is exact or one short; one compare of the remainder settles it.
	always_comb begin
		quot_est = prod_s3[61:32];
		rem      = {mag_s3, 3'b000} - 35'(quot_est) * 35'(DIVISOR);
		quot     = quot_est + 30'(rem >= 35'(DIVISOR));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (rdy1) begin
				valid_s1 <= in_valid;
			end
			if (rdy2) begin
				valid_s2 <= valid_s1;
			end
			if (rdy3) begin
				valid_s3 <= valid_s2;
			end
			if (rdy4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			target_s1 <= in_item.target_angle;
			stop_s1   <= in_item.stop;
			offset_s1 <= offset_next;
		end
		if (valid_s1 && rdy2) begin
			neg_s2 <= angle[31];
			mag_s2 <= angle[31] ? (32'd0 - angle) : angle;
		end
		if (valid_s2 && rdy3) begin
			neg_s3  <= neg_s2;
			mag_s3  <= mag_s2;
			prod_s3 <= 62'(mag_s2) * 62'(RECIP);
		end
		if (valid_s3 && rdy4) begin
			neg_s4  <= neg_s3;
			quot_s4 <= quot;
		end
	end

	always_comb begin
		unique case (pos_q)
			POS_SOF:    byte_c = BYTE_SOF;
			POS_ZERO:   byte_c = BYTE_ZERO;
			POS_ID:     byte_c = 8'(motor_index_q + 8'd1);
			POS_CMD:    byte_c = BYTE_CMD;
			POS_LEN:    byte_c = BYTE_LEN;
			POS_D0:     byte_c = counts_q[7:0];
			POS_D1:     byte_c = counts_q[15:8];
			POS_D2:     byte_c = counts_q[23:16];
			POS_D3:     byte_c = counts_q[31:24];
			POS_CRC_LO: byte_c = crc_q[7:0];
			POS_CRC_HI: byte_c = crc_q[15:8];
			default:    byte_c = BYTE_ZERO;
		endcase
	end

	assign out_valid           = ser_valid_q;
	assign out_item.frame_byte = byte_c;
	assign out_item.last       = (pos_q == POS_CRC_HI);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ser_valid_q <= 1'b0;
			pos_q       <= POS_SOF;
		end else if (ser_load) begin
			ser_valid_q <= valid_s4;
			pos_q       <= POS_SOF;
		end else if (out_acc) begin
			pos_q <= frame_pos_t'(pos_q + 4'd1);
		end
	end

	// The CRC takes in each of the first nine bytes as it is sent.
	always_ff @(posedge clk) begin
		if (ser_load && valid_s4) begin
			counts_q <= neg_s4 ? (32'd0 - {2'b00, quot_s4}) : {2'b00, quot_s4};
		end else if (out_acc && pos_q != POS_CRC_LO && pos_q != POS_CRC_HI) begin
			crc_q <= crc_byte((pos_q == POS_SOF) ? CRC_INIT : crc_q, byte_c);
		end
	end

endmodule

/* rtl/core/sacf_checker.sv */
module sacf_checker
	import sacf_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      out_valid,
	input logic      out_stall,
	input sacf_out_t out_item
);

	// Once reset has been seen held at an edge, nothing is offered at the next one.
	assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("output valid during reset");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("stalled output transaction changed");

	// Within a frame the bytes follow each other with no gap.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !out_item.last |=> out_valid)
		else $error("gap inside a frame");

	// A byte offered right after a frame ends opens the next frame.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && out_item.last |=>
			!out_valid || (out_item.frame_byte == BYTE_SOF && !out_item.last))
		else $error("frame does not start with the start byte");

endmodule

bind servo_angle_command_framer sacf_checker u_sacf_checker (.*);
